// ----- rtl/core/hash_index_key_to_rows_assert.svh -----
// Assertion macros used by the checker file of the hash index block.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef HASH_INDEX_KEY_TO_ROWS_ASSERT_SVH
`define HASH_INDEX_KEY_TO_ROWS_ASSERT_SVH

// Same-cycle implication.
`define HKR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash index assertion failed");

// Next-cycle implication.
`define HKR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash index assertion failed");

`endif

// ----- rtl/core/hkr_pkg.sv -----
// ----------------------------------------------------------------------------
// Hash index package
// Shared widths, operation and status codes, and divider status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hkr_pkg;

	localparam int KEY_W    = 64;
	localparam int ROW_W    = 32;
	localparam int CFG_W    = 11;
	localparam int ACT_W    = 2;
	localparam int STAT_W   = 2;
	localparam int DCNT_W   = 7;

	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/hkr_ifs.sv -----
// ----------------------------------------------------------------------------
// Hash index channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hkr_req_if import hkr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [KEY_W-1:0]  key;
	logic [ROW_W-1:0]  row_handle;
	modport source (output valid, action, key, row_handle, input ready);
	modport sink (input valid, action, key, row_handle, output ready);
endinterface

interface hkr_rsp_if import hkr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  row_out;
	logic              found;
	logic [STAT_W-1:0] status;
	logic              last;
	modport source (output valid, row_out, found, status, last, input ready);
	modport sink (input valid, row_out, found, status, last, output ready);
endinterface

interface hkr_cfg_if import hkr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hkr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hkr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hkr_div.sv -----
// ----------------------------------------------------------------------------
// Hash index divider
// Restoring divider of a 64-bit dividend by a narrow divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hkr_div import hkr_pkg::*; #(
	parameter int DW = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [KEY_W-1:0]  dividend,
	input  wire logic [DW-1:0]     divisor,
	output div_stat_t              stat,
	output logic      [KEY_W-1:0]  quotient,
	output logic      [DW-1:0]     remainder
);

	logic [KEY_W-1:0]  dvd_q;
	logic [KEY_W-1:0]  quo_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     dsr_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DW:0]       trial;
	logic              take;

	assign trial = {rem_q, dvd_q[KEY_W-1]};
	assign take  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DCNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(KEY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			quo_q <= {quo_q[KEY_W-2:0], take};
			rem_q <= take ? DW'(trial - {1'b0, dsr_q}) : DW'(trial);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/hash_index_key_to_rows.sv -----
// ----------------------------------------------------------------------------
// Hash index, key to rows
// Bucketed multimap from 64-bit keys to row handles with a shared divider.
// ----------------------------------------------------------------------------
// Channel  Role   Beat carries
// cfg      sink   bucket count
// req      sink   action, key, row handle
// rsp      source row, found flag, status, last flag
//
// An item passes through the shared divider twice (quotient, then remainder),
// then through a bucket scan that reads and checks the slots in turn.
// After reset a clearing pass writes the valid RAM, one bucket a cycle, over
// all MAX_BUCKETS buckets; no request is taken meanwhile.
// A stalled response beat holds the scan or the final beat until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hash_index_key_to_rows import hkr_pkg::*; #(
	parameter int MAX_BUCKETS = 1024,
	parameter int SLOTS       = 8,
	parameter int ROW_BITS    = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	hkr_cfg_if.sink  cfg,
	hkr_req_if.sink  req,
	hkr_rsp_if.source rsp
);

	localparam int DW = $clog2(MAX_BUCKETS + 1);
	localparam int BW = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
	localparam int SW = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int NENT = MAX_BUCKETS * SLOTS;
	localparam int AW = NENT > 1 ? $clog2(NENT) : 1;
	localparam int RW = ROW_BITS < ROW_W ? ROW_BITS : ROW_W;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_DIV1 = 4'd2;
	localparam logic [3:0] ST_DIV2 = 4'd3;
	localparam logic [3:0] ST_VRD  = 4'd4;
	localparam logic [3:0] ST_SRD  = 4'd5;
	localparam logic [3:0] ST_SCHK = 4'd6;
	localparam logic [3:0] ST_WR   = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0]        state_q;
	logic [CFG_W-1:0]  cfg_q;
	logic [DW-1:0]     bc_eff;
	logic [ACT_W-1:0]  act_q;
	logic [KEY_W-1:0]  key_q;
	logic [RW-1:0]     row_q;
	logic [BW-1:0]     bucket_q;
	logic [SW-1:0]     slot_q;
	logic [SW-1:0]     free_q;
	logic              free_v_q;
	logic [BW-1:0]     clr_q;
	logic [RW-1:0]     pend_q;
	logic              pend_v_q;
	logic [ROW_W-1:0]  res_row_q;
	logic              res_found_q;
	logic [STAT_W-1:0] res_stat_q;

	logic              out_v_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_found_q;
	logic [STAT_W-1:0] out_stat_q;
	logic              out_last_q;
	logic              out_free;
	logic              out_load;

	logic              div_start;
	logic [KEY_W-1:0]  div_dvd;
	div_stat_t         dstat;
	logic [KEY_W-1:0]  div_quo;
	logic [DW-1:0]     div_rem;

	logic              v_we;
	logic [BW-1:0]     v_waddr;
	logic [SLOTS-1:0]  v_wdata;
	logic              v_re;
	logic [SLOTS-1:0]  v_rdata;
	logic              e_we;
	logic              e_re;
	logic [AW-1:0]     e_addr;
	logic [AW-1:0]     e_waddr;
	logic [KEY_W+RW-1:0] e_rdata;
	logic [KEY_W-1:0]  e_key;
	logic [RW-1:0]     e_row;
	logic [SLOTS-1:0]  slot_oh;
	logic              slot_v;
	logic              key_hit;
	logic              pair_hit;
	logic              last_slot;

	always_comb begin
		if (cfg_q == '0) begin
			bc_eff = DW'(1);
		end else if (32'(cfg_q) > 32'(MAX_BUCKETS)) begin
			bc_eff = DW'(MAX_BUCKETS);
		end else begin
			bc_eff = DW'(cfg_q);
		end
	end

	assign out_free  = !out_v_q || rsp.ready;
	assign out_load  = out_free && ((state_q == ST_SCHK && act_q == ACT_LOOKUP &&
		key_hit && pend_v_q) || state_q == ST_FIN);
	assign slot_oh   = SLOTS'(1) << slot_q;
	assign slot_v    = |(v_rdata & slot_oh);
	assign e_key     = e_rdata[KEY_W+RW-1:RW];
	assign e_row     = e_rdata[RW-1:0];
	assign key_hit   = slot_v && (e_key == key_q);
	assign pair_hit  = key_hit && (e_row == row_q);
	assign last_slot = slot_q == SW'(SLOTS - 1);
	assign e_addr    = AW'(AW'(bucket_q) * AW'(SLOTS) + AW'(slot_q));
	assign e_waddr   = AW'(AW'(bucket_q) * AW'(SLOTS) + AW'(free_q));

	assign div_start = (state_q == ST_IDLE && req.valid) ||
		(state_q == ST_DIV1 && dstat.done);
	assign div_dvd   = (state_q == ST_IDLE) ? req.key : (key_q ^ div_quo);

	assign v_re = state_q == ST_VRD;
	assign e_re = state_q == ST_SRD;
	assign e_we = state_q == ST_WR;

	always_comb begin
		v_we    = 1'b0;
		v_waddr = bucket_q;
		v_wdata = v_rdata;
		if (state_q == ST_CLR) begin
			v_we    = 1'b1;
			v_waddr = clr_q;
			v_wdata = '0;
		end else if (state_q == ST_WR) begin
			v_we    = 1'b1;
			v_wdata = v_rdata | (SLOTS'(1) << free_q);
		end else if (state_q == ST_SCHK && act_q == ACT_REMOVE && pair_hit) begin
			v_we    = 1'b1;
			v_wdata = v_rdata & ~slot_oh;
		end
	end

	hkr_div #(.DW(DW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (bc_eff),
		.stat      (dstat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	hkr_ram #(.WIDTH(SLOTS), .DEPTH(MAX_BUCKETS)) u_valid_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.re    (v_re),
		.raddr (bucket_q),
		.rdata (v_rdata)
	);

	hkr_ram #(.WIDTH(KEY_W + RW), .DEPTH(NENT)) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata ({key_q, row_q}),
		.re    (e_re),
		.raddr (e_addr),
		.rdata (e_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			cfg_q    <= CFG_W'(MAX_BUCKETS);
			clr_q    <= '0;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
			free_v_q <= 1'b0;
			slot_q   <= '0;
		end else begin
			if (cfg.valid) begin
				cfg_q <= cfg.data;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(MAX_BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					pend_v_q <= 1'b0;
					free_v_q <= 1'b0;
					slot_q   <= '0;
					if (req.valid) begin
						if (req.action == ACT_LOOKUP || req.action == ACT_INSERT ||
							req.action == ACT_REMOVE) begin
							state_q <= ST_DIV1;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV1: begin
					if (dstat.done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (dstat.done) begin
						state_q <= ST_VRD;
					end
				end
				ST_VRD: begin
					state_q <= ST_SRD;
				end
				ST_SRD: begin
					state_q <= ST_SCHK;
				end
				ST_SCHK: begin
					if (act_q == ACT_LOOKUP) begin
						if (key_hit && pend_v_q) begin
							if (out_free) begin
								out_row_q   <= ROW_W'(pend_q);
								out_found_q <= 1'b1;
								out_stat_q  <= STAT_OK;
								out_last_q  <= 1'b0;
								pend_q      <= e_row;
								slot_q      <= slot_q + 1'b1;
								state_q     <= last_slot ? ST_FIN : ST_SRD;
							end
						end else begin
							if (key_hit) begin
								pend_q   <= e_row;
								pend_v_q <= 1'b1;
							end
							slot_q  <= slot_q + 1'b1;
							state_q <= last_slot ? ST_FIN : ST_SRD;
						end
					end else if (pair_hit) begin
						state_q <= ST_FIN;
					end else begin
						if (act_q == ACT_INSERT && !slot_v && !free_v_q) begin
							free_q   <= slot_q;
							free_v_q <= 1'b1;
						end
						slot_q <= slot_q + 1'b1;
						if (last_slot) begin
							if (act_q == ACT_INSERT && (free_v_q || !slot_v)) begin
								state_q <= ST_WR;
							end else begin
								state_q <= ST_FIN;
							end
						end else begin
							state_q <= ST_SRD;
						end
					end
				end
				ST_WR: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_last_q <= 1'b1;
						if (pend_v_q) begin
							out_row_q   <= ROW_W'(pend_q);
							out_found_q <= 1'b1;
							out_stat_q  <= STAT_OK;
						end else begin
							out_row_q   <= res_row_q;
							out_found_q <= res_found_q;
							out_stat_q  <= res_stat_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			act_q       <= req.action;
			key_q       <= req.key;
			row_q       <= RW'(req.row_handle);
			res_row_q   <= '0;
			res_found_q <= 1'b0;
			res_stat_q  <= STAT_NOTFOUND;
		end
		if (state_q == ST_DIV2 && dstat.done) begin
			bucket_q <= BW'(div_rem);
		end
		if (state_q == ST_SCHK && act_q != ACT_LOOKUP) begin
			if (pair_hit) begin
				res_stat_q <= STAT_OK;
			end else if (last_slot && act_q == ACT_INSERT) begin
				res_stat_q <= (free_v_q || !slot_v) ? STAT_OK : STAT_FULL;
			end
		end
	end

	assign cfg.ready   = 1'b1;
	assign req.ready   = state_q == ST_IDLE;
	assign rsp.valid   = out_v_q;
	assign rsp.row_out = out_row_q;
	assign rsp.found   = out_found_q;
	assign rsp.status  = out_stat_q;
	assign rsp.last    = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/hkr_checker.sv -----
// ----------------------------------------------------------------------------
// Hash index checker
// Port-level assertions on the hash index, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hash_index_key_to_rows_assert.svh"

module hkr_checker import hkr_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [ROW_W-1:0]  rsp_row_out,
	input wire logic              rsp_found,
	input wire logic [STAT_W-1:0] rsp_status
);

	`HKR_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)
	`HKR_ASSERT_IMP(a_row_zero, rsp_valid && !rsp_found, rsp_row_out == '0)
	`HKR_ASSERT_IMP(a_found_ok, rsp_valid && rsp_found, rsp_status == STAT_OK)
	`HKR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_out))

endmodule

bind hash_index_key_to_rows hkr_checker u_hkr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_row_out (rsp.row_out),
	.rsp_found   (rsp.found),
	.rsp_status  (rsp.status)
);

`default_nettype wire
